/* design/sld_pkg.sv */
// Shared types and constants for the sync/length deframer.
`timescale 1ns / 1ps

package sld_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SYNC  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_SYNC = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH  = 2'd2;

   localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'h55;
   localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET  = 8'd85;

   typedef enum logic [1:0] {
      PH_SYNC1   = 2'd0,
      PH_SYNC2   = 2'd1,
      PH_LENGTH  = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
      logic              status;
   } result_type;

endpackage

/* design/sld_in_stage.sv */
// Input register stage: captures one received word per accepted handshake.
`timescale 1ns / 1ps

module sld_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [sld_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                      consume,
   output logic                      held_valid,
   output logic [sld_pkg::BYTE_W-1:0] held_byte
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [sld_pkg::BYTE_W-1:0] byte_ff;
   logic                       take;

   assign req_stall = valid_ff && !consume;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

/* design/sld_core.sv */
// Frame state machine, configuration registers and per-word result logic.
`timescale 1ns / 1ps

module sld_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [sld_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sld_pkg::BYTE_W-1:0]      csr_data,
   input  logic                           step,
   input  logic [sld_pkg::BYTE_W-1:0]      rx_byte,
   output logic                           has_result,
   output sld_pkg::result_type            result
);

   logic [sld_pkg::BYTE_W-1:0] first_sync_ff;
   logic [sld_pkg::BYTE_W-1:0] second_sync_ff;
   logic [sld_pkg::BYTE_W-1:0] max_length_ff;

   sld_pkg::phase_type         phase_ff;
   sld_pkg::phase_type         phase_in;
   logic [sld_pkg::BYTE_W-1:0] frame_length_ff;
   logic [sld_pkg::BYTE_W-1:0] frame_length_in;
   logic [sld_pkg::BYTE_W-1:0] bytes_seen_ff;
   logic [sld_pkg::BYTE_W-1:0] bytes_seen_in;
   logic [sld_pkg::BYTE_W-1:0] bytes_next;
   logic                       is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= sld_pkg::FIRST_SYNC_RESET;
         second_sync_ff <= sld_pkg::SECOND_SYNC_RESET;
         max_length_ff  <= sld_pkg::MAX_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sld_pkg::CSR_FIRST_SYNC:  first_sync_ff  <= csr_data;
            sld_pkg::CSR_SECOND_SYNC: second_sync_ff <= csr_data;
            sld_pkg::CSR_MAX_LENGTH:  max_length_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sld_pkg::PH_SYNC1;
         frame_length_ff <= '0;
         bytes_seen_ff   <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_seen_ff   <= bytes_seen_in;
      end
   end

   assign bytes_next = bytes_seen_ff + 8'd1;
   assign is_last    = (bytes_next == frame_length_ff);

   always_comb begin
      phase_in         = phase_ff;
      frame_length_in  = frame_length_ff;
      bytes_seen_in    = bytes_seen_ff;
      has_result       = 1'b0;
      result.out_byte  = rx_byte;
      result.last_byte = 1'b0;
      result.status    = 1'b0;
      unique case (phase_ff)
         sld_pkg::PH_SYNC1: begin
            if (rx_byte == first_sync_ff) begin
               phase_in = sld_pkg::PH_SYNC2;
            end
         end
         sld_pkg::PH_SYNC2: begin
            if (rx_byte == second_sync_ff) begin
               phase_in = sld_pkg::PH_LENGTH;
            end else if (rx_byte != first_sync_ff) begin
               phase_in = sld_pkg::PH_SYNC1;
            end
         end
         sld_pkg::PH_LENGTH: begin
            if (rx_byte == '0 || rx_byte > max_length_ff) begin
               phase_in      = sld_pkg::PH_SYNC1;
               has_result    = 1'b1;
               result.status = 1'b1;
            end else begin
               phase_in        = sld_pkg::PH_PAYLOAD;
               frame_length_in = rx_byte;
               bytes_seen_in   = '0;
            end
         end
         sld_pkg::PH_PAYLOAD: begin
            bytes_seen_in    = bytes_next;
            has_result       = 1'b1;
            result.last_byte = is_last;
            if (is_last) begin
               phase_in = sld_pkg::PH_SYNC1;
            end
         end
         default: ;
      endcase
   end

endmodule

/* design/sld_out_stage.sv */
// Result register: holds one result word until the receiver takes it.
`timescale 1ns / 1ps

module sld_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  sld_pkg::result_type        result,
   output logic                       ready,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [sld_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_last_byte,
   output logic                       rsp_status
);

   logic                valid_ff;
   logic                valid_in;
   sld_pkg::result_type data_ff;

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = data_ff.out_byte;
   assign rsp_last_byte = data_ff.last_byte;
   assign rsp_status    = data_ff.status;

endmodule

/* design/sync_length_deframer_top.sv */
// Sync/length deframer top level: recovers length-prefixed frames from a byte stream.
//
// req channel: one received byte per word (req_valid, req_stall, req_rx_byte).
// rsp channel: one word per payload byte or rejected length (rsp_valid,
//   rsp_stall, rsp_out_byte, rsp_last_byte, rsp_status).
// csr port: csr_write with csr_index 0 first sync, 1 second sync, 2 max length;
//   other indexes are ignored. Write only while the block is idle.
// A result word passes through the input register and then the result register before it shows on rsp.
// Throughput: one byte per cycle while the receiver does not stall, set by the
//   single state step between the input register and the result register.
// Sync bytes, accepted lengths and bytes dropped while hunting give no word.
// Reset (synchronous): empties both registers, returns to hunting the first
//   sync byte and loads the default sync values and max length.
// Receiver stall: the result word holds; one more byte may sit in the input
//   register, after which req_stall rises.
`timescale 1ns / 1ps

module sync_length_deframer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sld_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sld_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                           rsp_last_byte,
   output logic                           rsp_status,
   input  logic                           csr_write,
   input  logic [sld_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sld_pkg::BYTE_W-1:0]      csr_data
);

   logic                       held_valid;
   logic [sld_pkg::BYTE_W-1:0] held_byte;
   logic                       out_ready;
   logic                       step;
   logic                       has_result;
   sld_pkg::result_type        result;

   assign step = held_valid && out_ready;

   sld_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .consume     (out_ready),
      .held_valid  (held_valid),
      .held_byte   (held_byte)
   );

   sld_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .step       (step),
      .rx_byte    (held_byte),
      .has_result (has_result),
      .result     (result)
   );

   sld_out_stage u_out (
      .clock         (clock),
      .reset         (reset),
      .load          (step && has_result),
      .result        (result),
      .ready         (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte),
      .rsp_status    (rsp_status)
   );

`ifndef SYNTH
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && held_valid))
      else $error("input stalled while result path is free");

   a_reject_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_status && rsp_last_byte))
      else $error("rejected length marked as frame end");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("registers not empty after reset");

   a_step_loads_result: assert property (@(posedge clock) disable iff (reset)
      (step && has_result) |=> rsp_valid)
      else $error("result word lost");
`endif

endmodule
